[hw/rtl/mqts_pkg.sv]
// Shared constants and types of the two-stack minimum queue.
`default_nettype none

package mqts_pkg;

   localparam int DEPTH    = 1024;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int VAL_W    = 32;
   localparam int ENTRY_W  = 2 * VAL_W;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 12;
   localparam int RSP_W    = 112;

   typedef enum logic [CMD_W-1:0] {
      CMD_QUERY = 2'd0,
      CMD_ENQ   = 2'd1,
      CMD_DEQ   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/mqts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mqts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/min_queue_two_stacks.sv]
// Top level of the minimum queue built from two minimum stacks held in RAM.
//
// Usage: a command arrives on the req_ stream (tuser = command, tdata = value).
// Every command gives exactly one result on the rsp_ stream with the status,
// the removed value, and the front, minimum and count after the command.
// The input stack and output stack each live in a RAM of mqts_pkg::DEPTH
// entries; the top entries and the bottom of the input stack are cached in
// registers so that most commands need no RAM read.
// Sequence: an item is taken in S_IDLE and executed in S_EXEC once the result
// register is free; query, enqueue, clear and dequeue of an empty queue or of a
// one-entry output stack finish there. A dequeue that must re-read the new top
// of the output stack passes through S_REFRESH. A dequeue that finds the output
// stack empty walks the input stack through the RAM read port, one entry a cycle.
// Reset clears both counts and the result valid flag; the RAMs are not cleared.
// Stalls: execution waits while the result register holds an untaken result;
// one further item is still accepted and waits in the item register.
`default_nettype none

module min_queue_two_stacks (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // bits 31:0 value
   input  wire logic [mqts_pkg::VAL_W-1:0]      req_tdata,
   // bits 1:0 command
   input  wire logic [mqts_pkg::CMD_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // bits 1:0 status, 33:2 removed_value, 65:34 front_value,
   // 97:66 min_value, 109:98 count, 111:110 zero
   output logic [mqts_pkg::RSP_W-1:0]           rsp_tdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_REFRESH,
      S_WALK
   } state_type;

   state_type state_ff, state_in;

   mqts_pkg::cmd_type                        cmd_ff, cmd_in;
   logic signed [mqts_pkg::VAL_W-1:0]        val_ff, val_in;
   logic [mqts_pkg::CNT_W-1:0]               in_cnt_ff, in_cnt_in;
   logic [mqts_pkg::CNT_W-1:0]               out_cnt_ff, out_cnt_in;
   logic signed [mqts_pkg::VAL_W-1:0]        in_min_ff, in_min_in;
   logic signed [mqts_pkg::VAL_W-1:0]        in_bot_ff, in_bot_in;
   logic signed [mqts_pkg::VAL_W-1:0]        out_val_ff, out_val_in;
   logic signed [mqts_pkg::VAL_W-1:0]        out_min_ff, out_min_in;
   logic signed [mqts_pkg::VAL_W-1:0]        rem_ff, rem_in;
   logic [mqts_pkg::ADDR_W-1:0]              rd_idx_ff, rd_idx_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [mqts_pkg::RSP_W-1:0]               rsp_data_ff, rsp_data_in;

   logic                                     in_wr_en, in_rd_en;
   logic [mqts_pkg::ADDR_W-1:0]              in_wr_addr, in_rd_addr;
   logic [mqts_pkg::ENTRY_W-1:0]             in_wr_data, in_rd_data;
   logic                                     out_wr_en, out_rd_en;
   logic [mqts_pkg::ADDR_W-1:0]              out_wr_addr, out_rd_addr;
   logic [mqts_pkg::ENTRY_W-1:0]             out_wr_data, out_rd_data;

   logic                                     out_free;
   logic                                     load_rsp;
   mqts_pkg::status_type                     status_n;
   logic signed [mqts_pkg::VAL_W-1:0]        removed_n;
   logic signed [mqts_pkg::VAL_W-1:0]        front_n;
   logic signed [mqts_pkg::VAL_W-1:0]        minv_n;
   logic signed [mqts_pkg::VAL_W-1:0]        push_min;
   logic signed [mqts_pkg::VAL_W-1:0]        walk_val;
   logic signed [mqts_pkg::VAL_W-1:0]        walk_min;
   logic [mqts_pkg::CNT_W-1:0]               in_cnt_m1;
   logic [mqts_pkg::CNT_W-1:0]               out_cnt_m2;
   logic [mqts_pkg::CNT_W:0]                 cnt_sum;

   mqts_ram #(
      .WIDTH (mqts_pkg::ENTRY_W),
      .DEPTH (mqts_pkg::DEPTH)
   ) u_in_store (
      .clock   (clock),
      .wr_en   (in_wr_en),
      .wr_addr (in_wr_addr),
      .wr_data (in_wr_data),
      .rd_en   (in_rd_en),
      .rd_addr (in_rd_addr),
      .rd_data (in_rd_data)
   );

   mqts_ram #(
      .WIDTH (mqts_pkg::ENTRY_W),
      .DEPTH (mqts_pkg::DEPTH)
   ) u_out_store (
      .clock   (clock),
      .wr_en   (out_wr_en),
      .wr_addr (out_wr_addr),
      .wr_data (out_wr_data),
      .rd_en   (out_rd_en),
      .rd_addr (out_rd_addr),
      .rd_data (out_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_cnt_m1  = in_cnt_ff - mqts_pkg::CNT_W'(1);
   assign out_cnt_m2 = out_cnt_ff - mqts_pkg::CNT_W'(2);
   assign walk_val   = $signed(in_rd_data[mqts_pkg::VAL_W-1:0]);

   // Running minimum of a new input stack entry.
   always_comb begin
      push_min = val_ff;
      if ((in_cnt_ff != '0) && (in_min_ff < val_ff)) begin
         push_min = in_min_ff;
      end
   end

   // Running minimum of an entry moved onto the output stack.
   always_comb begin
      walk_min = walk_val;
      if ((out_cnt_ff != '0) && (out_min_ff < walk_val)) begin
         walk_min = out_min_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      in_cnt_in    = in_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      in_min_in    = in_min_ff;
      in_bot_in    = in_bot_ff;
      out_val_in   = out_val_ff;
      out_min_in   = out_min_ff;
      rem_in       = rem_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      in_wr_en     = 1'b0;
      in_wr_addr   = in_cnt_ff[mqts_pkg::ADDR_W-1:0];
      in_wr_data   = {push_min, val_ff};
      in_rd_en     = 1'b0;
      in_rd_addr   = in_cnt_m1[mqts_pkg::ADDR_W-1:0];
      out_wr_en    = 1'b0;
      out_wr_addr  = out_cnt_ff[mqts_pkg::ADDR_W-1:0];
      out_wr_data  = {walk_min, walk_val};
      out_rd_en    = 1'b0;
      out_rd_addr  = out_cnt_m2[mqts_pkg::ADDR_W-1:0];
      load_rsp     = 1'b0;
      status_n     = mqts_pkg::ST_OK;
      removed_n    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = mqts_pkg::cmd_type'(req_tuser);
               val_in   = $signed(req_tdata);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               case (cmd_ff)
                  mqts_pkg::CMD_QUERY: begin
                     load_rsp = 1'b1;
                  end
                  mqts_pkg::CMD_ENQ: begin
                     load_rsp = 1'b1;
                     if (in_cnt_ff == mqts_pkg::CNT_W'(mqts_pkg::DEPTH)) begin
                        status_n = mqts_pkg::ST_FULL;
                     end else begin
                        in_wr_en  = 1'b1;
                        in_cnt_in = in_cnt_ff + mqts_pkg::CNT_W'(1);
                        in_min_in = push_min;
                        if (in_cnt_ff == '0) begin
                           in_bot_in = val_ff;
                        end
                     end
                  end
                  mqts_pkg::CMD_DEQ: begin
                     if ((in_cnt_ff == '0) && (out_cnt_ff == '0)) begin
                        status_n = mqts_pkg::ST_EMPTY;
                        load_rsp = 1'b1;
                     end else if (out_cnt_ff != '0) begin
                        removed_n  = out_val_ff;
                        out_cnt_in = out_cnt_ff - mqts_pkg::CNT_W'(1);
                        if (out_cnt_ff > mqts_pkg::CNT_W'(1)) begin
                           // The new top must be fetched before the result is known.
                           out_rd_en = 1'b1;
                           rem_in    = out_val_ff;
                           state_in  = S_REFRESH;
                        end else begin
                           load_rsp = 1'b1;
                        end
                     end else begin
                        in_rd_en  = 1'b1;
                        rd_idx_in = in_cnt_m1[mqts_pkg::ADDR_W-1:0];
                        state_in  = S_WALK;
                     end
                  end
                  mqts_pkg::CMD_CLEAR: begin
                     in_cnt_in  = '0;
                     out_cnt_in = '0;
                     load_rsp   = 1'b1;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         S_REFRESH: begin
            out_val_in = $signed(out_rd_data[mqts_pkg::VAL_W-1:0]);
            out_min_in = $signed(out_rd_data[mqts_pkg::ENTRY_W-1:mqts_pkg::VAL_W]);
            removed_n  = rem_ff;
            load_rsp   = 1'b1;
         end
         S_WALK: begin
            // Read data belongs to input entry rd_idx_ff; the bottom entry is
            // popped at once and never written to the output stack.
            if (rd_idx_ff != '0) begin
               out_wr_en  = 1'b1;
               out_val_in = walk_val;
               out_min_in = walk_min;
               out_cnt_in = out_cnt_ff + mqts_pkg::CNT_W'(1);
               in_rd_en   = 1'b1;
               in_rd_addr = rd_idx_ff - mqts_pkg::ADDR_W'(1);
               rd_idx_in  = rd_idx_ff - mqts_pkg::ADDR_W'(1);
            end else begin
               removed_n = walk_val;
               in_cnt_in = '0;
               load_rsp  = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      front_n = '0;
      minv_n  = '0;
      if (out_cnt_in != '0) begin
         front_n = out_val_in;
         minv_n  = out_min_in;
         if ((in_cnt_in != '0) && (in_min_in < out_min_in)) begin
            minv_n = in_min_in;
         end
      end else if (in_cnt_in != '0) begin
         front_n = in_bot_in;
         minv_n  = in_min_in;
      end
      cnt_sum = {1'b0, in_cnt_in} + {1'b0, out_cnt_in};

      if (load_rsp) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         rsp_data_in  = mqts_pkg::RSP_W'({mqts_pkg::COUNT_W'(cnt_sum), minv_n, front_n,
                                          removed_n, status_n});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      in_min_ff   <= in_min_in;
      in_bot_ff   <= in_bot_in;
      out_val_ff  <= out_val_in;
      out_min_ff  <= out_min_in;
      rem_ff      <= rem_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_in_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      in_cnt_ff <= mqts_pkg::CNT_W'(mqts_pkg::DEPTH))
      else $error("input stack count beyond depth");

   a_out_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= mqts_pkg::CNT_W'(mqts_pkg::DEPTH))
      else $error("output stack count beyond depth");

   a_walk_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (out_cnt_ff < in_cnt_ff))
      else $error("transfer overran the input stack");

   a_walk_slot_free: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WALK) || (state_ff == S_REFRESH)) |-> !rsp_valid_ff)
      else $error("result register busy during a multi-cycle dequeue");

   a_empty_removed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[mqts_pkg::STATUS_W-1:0] == mqts_pkg::ST_EMPTY))
      |-> (rsp_data_ff[mqts_pkg::STATUS_W +: mqts_pkg::VAL_W] == '0))
      else $error("empty dequeue reports a removed value");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> ((in_cnt_ff == '0) && (out_cnt_ff == '0) && !rsp_valid_ff))
      else $error("reset did not clear the queue");
`endif

endmodule

`default_nettype wire
